FILE: src/llwt_pkg.sv
// ----------------------------------------------------------------------------
// llwt_pkg: shared definitions of the least-loaded worker table
// Sizes, operation and status codes, cell interface structs and the load
// and key conversion helpers used by the cells and the top level.
// ----------------------------------------------------------------------------
package llwt_pkg;

   localparam int MAX_MACHINES = 16;
   localparam int KEY_BITS     = 16;
   localparam int LOAD_BITS    = 16;

   localparam int CNT_BITS = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

   localparam logic [31:0] LOAD_MAX32 = 32'hFFFF_FFFF >> (32 - LOAD_BITS);

   typedef enum logic [2:0] {
      OP_UPSERT     = 3'd0,
      OP_SET_ONLINE = 3'd1,
      OP_INC        = 3'd2,
      OP_DEC        = 3'd3,
      OP_QUERY      = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY_KEY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef logic [KEY_BITS-1:0]  key_type;
   typedef logic [LOAD_BITS-1:0] load_type;

   // Operation broadcast to every cell.
   typedef struct packed {
      op_type   op;
      key_type  key;
      load_type load;
      logic     online;
   } cmd_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic apply;
      logic ins;
   } cell_ctl_type;

   // Per-cell status back to the sequencer.
   typedef struct packed {
      logic     match;
      logic     valid;
      load_type load;
   } cell_stat_type;

   // Best candidate travelling down the row of cells.
   typedef struct packed {
      logic     valid;
      key_type  key;
      load_type load;
   } pick_type;

   function automatic key_type key_from_port(input logic [15:0] k);
      logic [63:0] wide;
      wide = {48'd0, k};
      return wide[KEY_BITS-1:0];
   endfunction

   function automatic logic [15:0] key_to_port(input key_type k);
      logic [63:0] wide;
      wide = 64'(k);
      return wide[15:0];
   endfunction

   function automatic load_type load_clamp(input logic signed [15:0] raw);
      logic [31:0] wide;
      if (raw[15]) begin
         wide = 32'd0;
      end else begin
         wide = {16'd0, raw};
         if (wide > LOAD_MAX32) begin
            wide = LOAD_MAX32;
         end
      end
      return wide[LOAD_BITS-1:0];
   endfunction

   function automatic logic [15:0] load_to_port(input load_type l);
      logic [31:0] wide;
      wide = 32'(l);
      return wide[15:0];
   endfunction

   function automatic load_type load_inc(input load_type l);
      return (l == '1) ? l : l + LOAD_BITS'(1);
   endfunction

   function automatic load_type load_dec(input load_type l);
      return (l == '0) ? l : l - LOAD_BITS'(1);
   endfunction

endpackage

FILE: src/least_loaded_worker_table_top.sv
// ----------------------------------------------------------------------------
// least_loaded_worker_table_top: table of workers with least-loaded pick
// Row of slot cells with a small sequencer that decodes one operation,
// applies it to the table and waits for the best pick to ripple out.
// ----------------------------------------------------------------------------
// Usage:
//   An operation item enters on the req_ channel (valid/ready). Each item
//   upserts, sets the online flag, increments, decrements or only queries
//   one entry, and yields exactly one result item on the rsp_ channel.
//   The result carries the status, the load after an increment or
//   decrement, and the online entry with the smallest load (smaller key on
//   ties) as it stands after the operation.
//   One item is in work at a time: the next item is accepted only once
//   the result of the last has been handed to the output register.
//   The time per item is set by the best-pick chain: every slot cell
//   registers its merged candidate, so the pick moves one cell per cycle
//   down the row. Key lookup and free-slot selection are combinational
//   parallel compares across all cells.
//   Reset (synchronous, active high) empties the table and drops any
//   pending result; no clearing pass is needed, since only valid bits reset.
//   The result sits in an output register. While the receiver stalls the
//   block still accepts the next item and works on it; it holds that
//   item's result in its last step until the output register is free.
// ----------------------------------------------------------------------------
module least_loaded_worker_table_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic [15:0]        req_machine_key,
   input  logic signed [15:0] req_new_load,
   input  logic               req_online_flag,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_load_after,
   output logic               rsp_pick_valid,
   output logic [15:0]        rsp_pick_key,
   output logic [15:0]        rsp_pick_load
);
   import llwt_pkg::*;

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MAX_MACHINES - 1);

   state_type              state_ff;
   state_type              state_in;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [CNT_BITS-1:0]    cnt_in;
   cmd_type                cmd_ff;
   cmd_type                cmd_in;
   status_type             status_ff;
   status_type             status_in;
   load_type               load_after_ff;
   load_type               load_after_in;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [1:0]             rsp_status_ff;
   logic [1:0]             rsp_status_in;
   logic [15:0]            rsp_load_after_ff;
   logic [15:0]            rsp_load_after_in;
   logic                   rsp_pick_valid_ff;
   logic                   rsp_pick_valid_in;
   logic [15:0]            rsp_pick_key_ff;
   logic [15:0]            rsp_pick_key_in;
   logic [15:0]            rsp_pick_load_ff;
   logic [15:0]            rsp_pick_load_in;

   cell_ctl_type           ctl    [MAX_MACHINES];
   cell_stat_type          stat   [MAX_MACHINES];
   pick_type               link   [MAX_MACHINES+1];

   logic [MAX_MACHINES-1:0] valid_vec;
   logic [MAX_MACHINES-1:0] match_vec;
   logic [MAX_MACHINES-1:0] free_onehot;
   logic                    any_match;
   logic                    table_full;
   logic                    empty_key;
   logic                    apply;
   logic                    insert_new;
   load_type                matched_load;
   status_type              dec_status;
   load_type                op_load;
   pick_type                pick_final;

   // ---------------------------------------------------------------------
   // Row of slot cells. The pick chain enters empty at the first cell.
   // ---------------------------------------------------------------------
   assign link[0] = '0;

   for (genvar i = 0; i < MAX_MACHINES; i++) begin : g_cell
      assign ctl[i].apply = apply;
      assign ctl[i].ins   = insert_new && free_onehot[i];
      assign valid_vec[i] = stat[i].valid;
      assign match_vec[i] = stat[i].match;

      llwt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd_ff),
         .ctl      (ctl[i]),
         .stat     (stat[i]),
         .pick_in  (link[i]),
         .pick_out (link[i+1])
      );
   end

   assign pick_final = link[MAX_MACHINES];

   // ---------------------------------------------------------------------
   // Lookup: key match across all cells, lowest free slot, old load of the
   // matching entry (at most one cell matches since keys are unique).
   // ---------------------------------------------------------------------
   assign any_match   = |match_vec;
   assign table_full  = &valid_vec;
   assign free_onehot = ~valid_vec & (valid_vec + MAX_MACHINES'(1));
   assign empty_key   = (cmd_ff.key == '0);

   always_comb begin
      matched_load = '0;
      for (int i = 0; i < MAX_MACHINES; i++) begin
         matched_load = matched_load | (match_vec[i] ? stat[i].load : '0);
      end
   end

   always_comb begin
      dec_status = ST_DONE;
      op_load    = '0;
      insert_new = 1'b0;
      unique case (cmd_ff.op)
         OP_UPSERT: begin
            if (empty_key) begin
               dec_status = ST_EMPTY_KEY;
            end else if (!any_match) begin
               if (table_full) dec_status = ST_FULL;
               else            insert_new = 1'b1;
            end
         end
         OP_SET_ONLINE: begin
            if (!any_match) dec_status = ST_NOT_FOUND;
         end
         OP_INC: begin
            if (!any_match) dec_status = ST_NOT_FOUND;
            else            op_load    = load_inc(matched_load);
         end
         OP_DEC: begin
            if (!any_match) dec_status = ST_NOT_FOUND;
            else            op_load    = load_dec(matched_load);
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: accept, decide and apply, let the pick ripple down the
   // row, then hand the result to the output register.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      cmd_in            = cmd_ff;
      status_in         = status_ff;
      load_after_in     = load_after_ff;
      req_ready         = 1'b0;
      apply             = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_load_after_in = rsp_load_after_ff;
      rsp_pick_valid_in = rsp_pick_valid_ff;
      rsp_pick_key_in   = rsp_pick_key_ff;
      rsp_pick_load_in  = rsp_pick_load_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_op) inside
                  OP_UPSERT, OP_SET_ONLINE, OP_INC, OP_DEC, OP_QUERY: begin
                     cmd_in.op = op_type'(req_op);
                  end
                  default: begin
                     cmd_in.op = OP_QUERY;
                  end
               endcase
               cmd_in.key    = key_from_port(req_machine_key);
               cmd_in.load   = load_clamp(req_new_load);
               cmd_in.online = req_online_flag;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            apply         = !((cmd_ff.op == OP_UPSERT) && empty_key);
            status_in     = dec_status;
            load_after_in = op_load;
            cnt_in        = '0;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_LAST) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_load_after_in = load_to_port(load_after_ff);
               rsp_pick_valid_in = pick_final.valid;
               rsp_pick_key_in   = pick_final.valid ? key_to_port(pick_final.key) : 16'd0;
               rsp_pick_load_in  = pick_final.valid ? load_to_port(pick_final.load) : 16'd0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      status_ff         <= status_in;
      load_after_ff     <= load_after_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_load_after_ff <= rsp_load_after_in;
      rsp_pick_valid_ff <= rsp_pick_valid_in;
      rsp_pick_key_ff   <= rsp_pick_key_in;
      rsp_pick_load_ff  <= rsp_pick_load_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_load_after = rsp_load_after_ff;
   assign rsp_pick_valid = rsp_pick_valid_ff;
   assign rsp_pick_key   = rsp_pick_key_ff;
   assign rsp_pick_load  = rsp_pick_load_ff;

endmodule

FILE: src/llwt_cell.sv
// ----------------------------------------------------------------------------
// llwt_cell: one slot of the worker table
// Holds one entry, applies the broadcast operation when it matches or is
// chosen for insertion, and merges its entry into the passing best pick.
// ----------------------------------------------------------------------------
module llwt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  llwt_pkg::cmd_type      cmd,
   input  llwt_pkg::cell_ctl_type ctl,
   output llwt_pkg::cell_stat_type stat,
   input  llwt_pkg::pick_type     pick_in,
   output llwt_pkg::pick_type     pick_out
);
   import llwt_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   key_type  key_ff;
   key_type  key_in;
   load_type load_ff;
   load_type load_in;
   logic     online_ff;
   logic     online_in;
   pick_type pick_ff;
   pick_type pick_in_next;
   pick_type own;
   logic     match;

   assign match = valid_ff && (key_ff == cmd.key);

   assign stat.match = match;
   assign stat.valid = valid_ff;
   assign stat.load  = load_ff;

   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      load_in   = load_ff;
      online_in = online_ff;
      if (ctl.apply) begin
         unique case (cmd.op)
            OP_UPSERT: begin
               if (match || ctl.ins) begin
                  valid_in  = 1'b1;
                  key_in    = cmd.key;
                  load_in   = cmd.load;
                  online_in = cmd.online;
               end
            end
            OP_SET_ONLINE: begin
               if (match) online_in = cmd.online;
            end
            OP_INC: begin
               if (match) load_in = load_inc(load_ff);
            end
            OP_DEC: begin
               if (match) load_in = load_dec(load_ff);
            end
            default: begin
            end
         endcase
      end
   end

   // Keys in the table are unique, so the merge order along the row does
   // not change the winner.
   always_comb begin
      own.valid = valid_ff && online_ff;
      own.key   = key_ff;
      own.load  = load_ff;
      if (!own.valid) begin
         pick_in_next = pick_in;
      end else if (!pick_in.valid) begin
         pick_in_next = own;
      end else if ((own.load < pick_in.load) ||
                   ((own.load == pick_in.load) && (own.key < pick_in.key))) begin
         pick_in_next = own;
      end else begin
         pick_in_next = pick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         pick_ff.valid <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pick_ff  <= pick_in_next;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      load_ff   <= load_in;
      online_ff <= online_in;
   end

   assign pick_out = pick_ff;

endmodule
